FILE: rtl/tpts_pkg.sv
// ---------------------------------------------------------------------------
// Tape pulse tone sequencer package
// Shared constants, command and table entry types for the sequencer blocks.
// ---------------------------------------------------------------------------
package tpts_pkg;

	// Table depth and the widths that follow from it.
	localparam int MAX_TONES = 64;
	localparam int IDX_W     = $clog2(MAX_TONES);
	localparam int CNT_W     = $clog2(MAX_TONES + 1);

	localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_TONES);

	localparam int LEN_W = 32;
	localparam int PC_W  = 16;

	typedef enum logic [1:0] {
		OP_CLEAR  = 2'd0,
		OP_TONE   = 2'd1,
		OP_DIRECT = 2'd2,
		OP_NEXT   = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ERR_OK    = 2'd0,
		ERR_FULL  = 2'd1,
		ERR_EMPTY = 2'd2
	} err_t;

	// Classified command as it sits in the queue between front and back.
	typedef struct packed {
		op_t             op;
		logic            level;
		logic [LEN_W-1:0] length;
		logic [PC_W-1:0]  count;
	} cmd_t;

	// One table entry as stored in the segment memory.
	typedef struct packed {
		logic [LEN_W-1:0] length;
		logic [PC_W-1:0]  count;
		logic             direct;
		logic             level;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	// One result beat.
	typedef struct packed {
		logic             event_valid;
		logic [LEN_W-1:0] delay;
		logic             next_level;
		logic             present_level;
		logic             at_end;
		err_t             error_code;
	} res_t;

endpackage

FILE: rtl/tpts_in_if.sv
// ---------------------------------------------------------------------------
// Sequencer request channel
// Valid/ready channel that carries one input item per beat.
// ---------------------------------------------------------------------------
interface tpts_in_if;
	logic        valid;
	logic        ready;
	logic [1:0]  kind;
	logic        level;
	logic [31:0] pulse_length;
	logic [15:0] pulse_count;

	modport source (output valid, output kind, output level, output pulse_length,
		output pulse_count, input ready);
	modport sink (input valid, input kind, input level, input pulse_length,
		input pulse_count, output ready);
endinterface

FILE: rtl/tpts_out_if.sv
// ---------------------------------------------------------------------------
// Sequencer result channel
// Valid/ready channel that carries one result item per beat.
// ---------------------------------------------------------------------------
interface tpts_out_if;
	logic        valid;
	logic        ready;
	logic        event_valid;
	logic [31:0] delay;
	logic        next_level;
	logic        present_level;
	logic        at_end;
	logic [1:0]  error_code;

	modport source (output valid, output event_valid, output delay, output next_level,
		output present_level, output at_end, output error_code, input ready);
	modport sink (input valid, input event_valid, input delay, input next_level,
		input present_level, input at_end, input error_code, output ready);
endinterface

FILE: rtl/tape_pulse_tone_sequencer_unit.sv
// ---------------------------------------------------------------------------
// Tape pulse tone sequencer
// Loads a table of tone and direct pulse segments and plays it pulse by pulse.
// ---------------------------------------------------------------------------
//
//   Channel  Dir  Beat contents
//   -------  ---  --------------------------------------------------------
//   req      in   kind, level, pulse_length, pulse_count (one item)
//   rsp      out  event_valid, delay, next_level, present_level, at_end,
//                 error_code (exactly one result per request)
//
// A request beat first lands in a two-entry command queue, then the back end
// executes it. Clear and add commands form their result when the back end
// takes them. A next request with pulses pending reads the table to look at
// the following entry, then forms the event. When a new segment must
// be loaded, each table entry read costs one more cycle, so skipping empty
// tones adds a cycle per skipped entry; the single table read port sets this.
// Reset clears all control state; the table itself is left as is and only
// entries below the fill count are ever read. The queue keeps taking
// requests while a result beat waits on rsp, and the back end only starts a
// command once the result register is free.
//
module tape_pulse_tone_sequencer_unit
	import tpts_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	tpts_in_if.sink    req,
	tpts_out_if.source rsp
);

	// Classified commands travel from the front queue to the back end.
	cmd_t cmd;
	logic cmd_valid;
	logic cmd_ready;

	tpts_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cmd       (cmd),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready)
	);

	// The back end owns the segment table, the play position and the level.
	tpts_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.rsp       (rsp)
	);

endmodule

FILE: rtl/tpts_ram.sv
// ---------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port, one read port, registered read data.
// ---------------------------------------------------------------------------
module tpts_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

FILE: rtl/tpts_front.sv
// ---------------------------------------------------------------------------
// Sequencer front end
// Accepts request beats, classifies them and queues the commands.
// ---------------------------------------------------------------------------
module tpts_front
	import tpts_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	tpts_in_if.sink req,
	output cmd_t    cmd,
	output logic    cmd_valid,
	input  logic    cmd_ready
);

	localparam int QDEPTH = 2;
	localparam int QP_W   = $clog2(QDEPTH);
	localparam int QC_W   = $clog2(QDEPTH + 1);

	cmd_t            queue_q [QDEPTH];
	logic [QP_W-1:0] wr_ptr_q;
	logic [QP_W-1:0] rd_ptr_q;
	logic [QC_W-1:0] fill_q;
	cmd_t            cls;
	logic            push;
	logic            pop;

	// A direct pulse is stored as a one-pulse segment; tones carry no level.
	always_comb begin
		cls.op     = op_t'(req.kind);
		cls.length = req.pulse_length;
		cls.count  = req.pulse_count;
		cls.level  = req.level;
		case (cls.op)
			OP_DIRECT: cls.count = PC_W'(1);
			OP_TONE:   cls.level = 1'b0;
			default:   ;
		endcase
	end

	assign req.ready = (fill_q != QC_W'(QDEPTH));
	assign push      = req.valid && req.ready;
	assign cmd_valid = (fill_q != '0);
	assign pop       = cmd_valid && cmd_ready;
	assign cmd       = queue_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QP_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QP_W'(1);
			end
			case ({push, pop})
				2'b10:   fill_q <= fill_q + QC_W'(1);
				2'b01:   fill_q <= fill_q - QC_W'(1);
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			queue_q[wr_ptr_q] <= cls;
		end
	end

endmodule

FILE: rtl/tpts_back.sv
// ---------------------------------------------------------------------------
// Sequencer back end
// Executes queued commands against the segment table and plays pulses.
// ---------------------------------------------------------------------------
module tpts_back
	import tpts_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  cmd_t        cmd,
	input  logic        cmd_valid,
	output logic        cmd_ready,
	tpts_out_if.source  rsp
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_FETCH,
		ST_FINISH
	} state_t;

	state_t            state_q;
	logic [CNT_W-1:0]  tones_q;
	logic [CNT_W-1:0]  play_q;
	logic [PC_W-1:0]   pulses_q;
	logic [LEN_W-1:0]  act_len_q;
	logic              act_dir_q;
	logic              sig_q;
	logic              use_peek_q;
	logic              out_valid_q;
	res_t              res_q;

	logic              out_free;
	logic              take;
	logic [CNT_W-1:0]  play_nx;
	logic              ram_we;
	logic              ram_re;
	logic [IDX_W-1:0]  ram_raddr;
	entry_t            wr_entry;
	entry_t            rd_entry;
	logic [ENTRY_W-1:0] rd_raw;
	logic              fetch_sig;
	logic              end_lvl;
	logic [PC_W-1:0]   pulses_dec;

	assign out_free  = !out_valid_q || rsp.ready;
	assign take      = (state_q == ST_IDLE) && cmd_valid && out_free;
	assign cmd_ready = take;
	assign play_nx   = play_q + CNT_W'(1);
	assign rd_entry  = entry_t'(rd_raw);

	assign wr_entry.length = cmd.length;
	assign wr_entry.count  = cmd.count;
	assign wr_entry.direct = (cmd.op == OP_DIRECT);
	assign wr_entry.level  = cmd.level;

	// Table port control: adds write at the fill position, next requests read
	// the play position and then each following entry as it is consumed.
	always_comb begin
		ram_we    = take && (cmd.op == OP_TONE || cmd.op == OP_DIRECT) && (tones_q != MAX_CNT);
		ram_re    = 1'b0;
		ram_raddr = play_q[IDX_W-1:0];
		case (state_q)
			ST_IDLE: begin
				ram_re = take && (cmd.op == OP_NEXT) && (play_q < tones_q);
			end
			ST_FETCH: begin
				ram_re    = (play_nx < tones_q);
				ram_raddr = play_nx[IDX_W-1:0];
			end
			default: ;
		endcase
	end

	// Level after a freshly fetched entry, and the level at the end of a pulse.
	assign fetch_sig  = rd_entry.direct ? rd_entry.level : sig_q;
	assign end_lvl    = (use_peek_q && rd_entry.direct) ? rd_entry.level :
		(act_dir_q ? sig_q : !sig_q);
	assign pulses_dec = pulses_q - PC_W'(1);

	tpts_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (MAX_TONES)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (tones_q[IDX_W-1:0]),
		.wdata (wr_entry),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (rd_raw)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			tones_q     <= '0;
			play_q      <= '0;
			pulses_q    <= '0;
			act_len_q   <= '0;
			act_dir_q   <= 1'b0;
			sig_q       <= 1'b0;
			use_peek_q  <= 1'b0;
			out_valid_q <= 1'b0;
			res_q       <= '0;
		end else begin
			if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (take) begin
						res_q.event_valid   <= 1'b0;
						res_q.delay         <= '0;
						res_q.next_level    <= 1'b0;
						res_q.present_level <= sig_q;
						res_q.error_code    <= ERR_OK;
						case (cmd.op)
							OP_CLEAR: begin
								tones_q             <= '0;
								play_q              <= '0;
								pulses_q            <= '0;
								act_len_q           <= '0;
								act_dir_q           <= 1'b0;
								sig_q               <= cmd.level;
								res_q.present_level <= cmd.level;
								res_q.at_end        <= 1'b1;
								out_valid_q         <= 1'b1;
							end
							OP_TONE, OP_DIRECT: begin
								out_valid_q <= 1'b1;
								if (tones_q == MAX_CNT) begin
									res_q.error_code <= ERR_FULL;
									res_q.at_end     <= (pulses_q == '0) && (play_q == tones_q);
								end else begin
									tones_q      <= tones_q + CNT_W'(1);
									res_q.at_end <= (pulses_q == '0) &&
										(play_q == tones_q + CNT_W'(1));
									if (cmd.op == OP_DIRECT && play_q == tones_q) begin
										sig_q               <= cmd.level;
										res_q.present_level <= cmd.level;
									end
								end
							end
							default: begin
								if (pulses_q == '0 && !(play_q < tones_q)) begin
									res_q.error_code <= ERR_EMPTY;
									res_q.at_end     <= 1'b1;
									out_valid_q      <= 1'b1;
								end else if (pulses_q == '0) begin
									state_q <= ST_FETCH;
								end else begin
									use_peek_q <= (play_q < tones_q);
									state_q    <= ST_FINISH;
								end
							end
						endcase
					end
				end
				ST_FETCH: begin
					pulses_q  <= rd_entry.count;
					act_len_q <= rd_entry.length;
					act_dir_q <= rd_entry.direct;
					sig_q     <= fetch_sig;
					play_q    <= play_nx;
					if (rd_entry.count == '0) begin
						// Empty segment: keep searching, or give up at the end.
						if (!(play_nx < tones_q)) begin
							res_q.event_valid   <= 1'b0;
							res_q.delay         <= '0;
							res_q.next_level    <= 1'b0;
							res_q.present_level <= fetch_sig;
							res_q.at_end        <= 1'b1;
							res_q.error_code    <= ERR_EMPTY;
							out_valid_q         <= 1'b1;
							state_q             <= ST_IDLE;
						end
					end else begin
						use_peek_q <= (play_nx < tones_q);
						state_q    <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					sig_q               <= end_lvl;
					pulses_q            <= pulses_dec;
					res_q.event_valid   <= 1'b1;
					res_q.delay         <= act_len_q;
					res_q.next_level    <= end_lvl;
					res_q.present_level <= end_lvl;
					res_q.at_end        <= (pulses_dec == '0) && (play_q == tones_q);
					res_q.error_code    <= ERR_OK;
					out_valid_q         <= 1'b1;
					state_q             <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign rsp.valid         = out_valid_q;
	assign rsp.event_valid   = res_q.event_valid;
	assign rsp.delay         = res_q.delay;
	assign rsp.next_level    = res_q.next_level;
	assign rsp.present_level = res_q.present_level;
	assign rsp.at_end        = res_q.at_end;
	assign rsp.error_code    = res_q.error_code;

	a_play_in_table: assert property (@(posedge clk) disable iff (!arst_n)
		play_q <= tones_q)
		else $error("play position beyond the loaded table");

	a_table_bound: assert property (@(posedge clk) disable iff (!arst_n)
		tones_q <= MAX_CNT)
		else $error("table fill beyond its depth");

	a_finish_has_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_FINISH |-> pulses_q != '0)
		else $error("pulse played with no pulse pending");

	a_fetch_after_read: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_FETCH |-> $past(ram_re))
		else $error("entry fetched without a table read");

	a_event_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && res_q.event_valid |-> res_q.error_code == ERR_OK)
		else $error("event beat carries an error code");

endmodule

FILE: dv/tb_tape_pulse_tone_sequencer_unit.sv
// ---------------------------------------------------------------------------
// Tape pulse tone sequencer testbench
// Drives table loads, clears and next requests through the request channel,
// predicts every result beat with a local model of the segment table and
// compares each result beat field by field, with random idling on both sides in all but the last phase.
// ---------------------------------------------------------------------------
module tb_tape_pulse_tone_sequencer_unit;
	import tpts_pkg::*;

	// Random items after the directed table, idle cycles after the last
	// expected result, and the number of quiet cycles that counts as a hang.
	localparam int RANDOM_ITEMS = 800;
	localparam int TAIL_CYCLES  = 70;
	localparam int QUIET_LIMIT  = 4000;
	localparam int PLAN_ROWS    = 22;

	// One row of the directed table. When typed is set, want holds a result
	// that can be read straight off the behavior; otherwise the predictor
	// supplies the expected result.
	typedef struct {
		cmd_t cmd;
		int   reps;
		bit   typed;
		res_t want;
	} plan_row_t;

	localparam res_t NO_WANT = '0;

	logic clk;
	logic arst_n;

	tpts_in_if  req_ch ();
	tpts_out_if rsp_ch ();

	tape_pulse_tone_sequencer_unit uut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	// Local copy of the segment table and the playback state.
	logic [LEN_W-1:0] seg_len    [MAX_TONES];
	logic [PC_W-1:0]  seg_cnt    [MAX_TONES];
	logic             seg_direct [MAX_TONES];
	logic             seg_lvl    [MAX_TONES];
	int unsigned      n_loaded;
	int unsigned      play_pos;
	logic [PC_W-1:0]  pulses_pending;
	logic [LEN_W-1:0] cur_len;
	logic             cur_direct;
	logic             level_now;

	res_t        pending_results [$];
	cmd_t        cmd_backlog [$];
	int          mismatches;
	int          src_idle_pct;
	int          sink_idle_pct;
	int unsigned quiet;

	// The directed table. It opens with a next request on an empty table,
	// walks the extremes of length and count, plays through a zero-pulse
	// tone and a direct pulse with the look-ahead on the following level,
	// and fills the table so that further adds are refused, then plays and clears.
	plan_row_t plan [PLAN_ROWS] = '{
		'{'{OP_NEXT,   1'b0, 32'h0000_0000, 16'h0000},  1, 1'b1,
			'{1'b0, 32'h0, 1'b0, 1'b0, 1'b1, ERR_EMPTY}},
		'{'{OP_CLEAR,  1'b1, 32'h0000_0000, 16'h0000},  1, 1'b1,
			'{1'b0, 32'h0, 1'b0, 1'b1, 1'b1, ERR_OK}},
		'{'{OP_NEXT,   1'b0, 32'h0000_0000, 16'h0000},  1, 1'b1,
			'{1'b0, 32'h0, 1'b0, 1'b1, 1'b1, ERR_EMPTY}},
		'{'{OP_DIRECT, 1'b0, 32'hFFFF_FFFF, 16'h0000},  1, 1'b1,
			'{1'b0, 32'h0, 1'b0, 1'b0, 1'b0, ERR_OK}},
		'{'{OP_TONE,   1'b0, 32'h0000_0000, 16'h0000},  1, 1'b0, NO_WANT},
		'{'{OP_TONE,   1'b1, 32'h1234_5678, 16'h0002},  1, 1'b0, NO_WANT},
		'{'{OP_DIRECT, 1'b1, 32'h0000_0000, 16'hFFFF},  1, 1'b0, NO_WANT},
		'{'{OP_TONE,   1'b0, 32'hFFFF_FFFF, 16'hFFFF},  1, 1'b0, NO_WANT},
		'{'{OP_NEXT,   1'b1, 32'hFFFF_FFFF, 16'hFFFF},  6, 1'b0, NO_WANT},
		'{'{OP_CLEAR,  1'b0, 32'h0000_0000, 16'h0000},  1, 1'b1,
			'{1'b0, 32'h0, 1'b0, 1'b0, 1'b1, ERR_OK}},
		'{'{OP_TONE,   1'b0, 32'hA5A5_A5A5, 16'h5A5A},  1, 1'b0, NO_WANT},
		'{'{OP_TONE,   1'b1, 32'h5A5A_5A5A, 16'h0000},  3, 1'b0, NO_WANT},
		'{'{OP_NEXT,   1'b0, 32'h0000_0000, 16'h0000},  2, 1'b0, NO_WANT},
		'{'{OP_CLEAR,  1'b1, 32'h0000_0000, 16'h0000},  1, 1'b1,
			'{1'b0, 32'h0, 1'b0, 1'b1, 1'b1, ERR_OK}},
		'{'{OP_TONE,   1'b0, 32'h0000_0007, 16'h0000},  4, 1'b0, NO_WANT},
		'{'{OP_NEXT,   1'b0, 32'h0000_0000, 16'h0000},  1, 1'b1,
			'{1'b0, 32'h0, 1'b0, 1'b1, 1'b1, ERR_EMPTY}},
		'{'{OP_CLEAR,  1'b0, 32'h0000_0000, 16'h0000},  1, 1'b1,
			'{1'b0, 32'h0, 1'b0, 1'b0, 1'b1, ERR_OK}},
		'{'{OP_TONE,   1'b0, 32'h0000_0001, 16'h0001}, 64, 1'b0, NO_WANT},
		'{'{OP_DIRECT, 1'b1, 32'hFFFF_FFFF, 16'h0000},  1, 1'b1,
			'{1'b0, 32'h0, 1'b0, 1'b0, 1'b0, ERR_FULL}},
		'{'{OP_TONE,   1'b0, 32'hFFFF_FFFF, 16'hFFFF},  1, 1'b1,
			'{1'b0, 32'h0, 1'b0, 1'b0, 1'b0, ERR_FULL}},
		'{'{OP_NEXT,   1'b0, 32'h0000_0000, 16'h0000},  3, 1'b0, NO_WANT},
		'{'{OP_CLEAR,  1'b0, 32'hFFFF_FFFF, 16'hFFFF},  1, 1'b1,
			'{1'b0, 32'h0, 1'b0, 1'b0, 1'b1, ERR_OK}}
	};

	// Two time units per period.
	initial clk = 1'b0;
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Works out the result of one accepted command and advances the local
	// playback state. A next request first consumes segments that have no
	// pulses left; if the table runs dry it answers with the empty error and
	// those segments stay consumed. The level after a pulse is the flipped
	// level for a tone and the held level for a direct pulse, unless the
	// segment that follows is a direct pulse, whose level then wins early.
	function automatic res_t predict_pulse_event(cmd_t c);
		res_t r;
		logic lvl_after;
		r = '0;
		r.error_code = ERR_OK;
		case (c.op)
			OP_CLEAR: begin
				n_loaded       = 0;
				play_pos       = 0;
				pulses_pending = '0;
				cur_len        = '0;
				cur_direct     = 1'b0;
				level_now      = c.level;
			end
			OP_TONE, OP_DIRECT: begin
				if (n_loaded >= MAX_TONES) begin
					r.error_code = ERR_FULL;
				end else begin
					seg_len[n_loaded]    = c.length;
					seg_cnt[n_loaded]    = (c.op == OP_DIRECT) ? PC_W'(1) : c.count;
					seg_direct[n_loaded] = (c.op == OP_DIRECT);
					seg_lvl[n_loaded]    = (c.op == OP_DIRECT) ? c.level : 1'b0;
					// A direct pulse added right at the play position sets the
					// line level at once.
					if (c.op == OP_DIRECT && play_pos == n_loaded)
						level_now = c.level;
					n_loaded++;
				end
			end
			default: begin
				while (pulses_pending == 0 && play_pos < n_loaded) begin
					pulses_pending = seg_cnt[play_pos];
					cur_len        = seg_len[play_pos];
					cur_direct     = seg_direct[play_pos];
					if (cur_direct)
						level_now = seg_lvl[play_pos];
					play_pos++;
				end
				if (pulses_pending == 0) begin
					r.error_code = ERR_EMPTY;
				end else begin
					lvl_after = cur_direct ? level_now : ~level_now;
					if (play_pos < n_loaded && seg_direct[play_pos])
						lvl_after = seg_lvl[play_pos];
					r.event_valid  = 1'b1;
					r.delay        = cur_len;
					r.next_level   = lvl_after;
					level_now      = lvl_after;
					pulses_pending = pulses_pending - PC_W'(1);
				end
			end
		endcase
		r.present_level = level_now;
		r.at_end        = (pulses_pending == 0 && play_pos == n_loaded);
		return r;
	endfunction

	function automatic cmd_t make_cmd(op_t op, logic lvl, logic [LEN_W-1:0] len,
		logic [PC_W-1:0] cnt);
		cmd_t c;
		c.op     = op;
		c.level  = lvl;
		c.length = len;
		c.count  = cnt;
		return c;
	endfunction

	// Pulse lengths: mostly any 32-bit value, now and then an extreme.
	function automatic logic [LEN_W-1:0] pick_length();
		int r;
		r = $urandom_range(0, 99);
		if (r < 5)
			return '0;
		if (r < 10)
			return '1;
		return $urandom();
	endfunction

	// Tone pulse counts: mostly a few pulses so that playback reaches the end
	// of the table, with empty tones and the odd long one mixed in.
	function automatic logic [PC_W-1:0] pick_count();
		int r;
		r = $urandom_range(0, 99);
		if (r < 15)
			return '0;
		if (r < 85)
			return PC_W'($urandom_range(1, 3));
		if (r < 96)
			return PC_W'($urandom_range(4, 12));
		return PC_W'($urandom_range(0, 65535));
	endfunction

	function automatic cmd_t any_cmd();
		return make_cmd(op_t'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
			$urandom(), PC_W'($urandom_range(0, 65535)));
	endfunction

	function automatic cmd_t any_segment();
		if ($urandom_range(0, 99) < 40)
			return make_cmd(OP_DIRECT, 1'($urandom_range(0, 1)), pick_length(),
				PC_W'($urandom_range(0, 65535)));
		return make_cmd(OP_TONE, 1'($urandom_range(0, 1)), pick_length(), pick_count());
	endfunction

	// Queues up the next stretch of random commands. Most stretches are a
	// whole tape: a clear, a handful of segments with an occasional early
	// next in between, and then next requests for the pulses loaded, up to 40, and one or two more.
	// The rest are loose noise and runs that fill the table past its depth.
	task automatic plan_tape();
		int r;
		int nseg;
		int npulses;
		cmd_t seg;
		r = $urandom_range(0, 99);
		if (r < 8) begin
			repeat ($urandom_range(1, 4))
				cmd_backlog.push_back(any_cmd());
		end else if (r < 12) begin
			cmd_backlog.push_back(make_cmd(OP_CLEAR, 1'($urandom_range(0, 1)),
				$urandom(), PC_W'($urandom_range(0, 65535))));
			repeat (MAX_TONES + $urandom_range(1, 3)) begin
				seg = any_segment();
				if (seg.op == OP_TONE)
					seg.count = PC_W'($urandom_range(0, 2));
				cmd_backlog.push_back(seg);
			end
			repeat ($urandom_range(1, 6))
				cmd_backlog.push_back(make_cmd(OP_NEXT, 1'($urandom_range(0, 1)),
					$urandom(), PC_W'($urandom_range(0, 65535))));
		end else begin
			cmd_backlog.push_back(make_cmd(OP_CLEAR, 1'($urandom_range(0, 1)),
				$urandom(), PC_W'($urandom_range(0, 65535))));
			nseg    = $urandom_range(1, 10);
			npulses = 0;
			repeat (nseg) begin
				seg = any_segment();
				npulses += (seg.op == OP_DIRECT) ? 1 : int'(seg.count);
				cmd_backlog.push_back(seg);
				if ($urandom_range(0, 99) < 15)
					cmd_backlog.push_back(make_cmd(OP_NEXT, 1'($urandom_range(0, 1)),
						$urandom(), PC_W'($urandom_range(0, 65535))));
				if ($urandom_range(0, 99) < 5)
					cmd_backlog.push_back(any_cmd());
			end
			if (npulses > 40)
				npulses = 40;
			repeat (npulses + $urandom_range(1, 2))
				cmd_backlog.push_back(make_cmd(OP_NEXT, 1'($urandom_range(0, 1)),
					$urandom(), PC_W'($urandom_range(0, 65535))));
		end
	endtask

	// Offers one request beat, idling first at the current sender rate, and
	// records the expected result once the beat has been taken. Ready is
	// read right after the edge, before any register of the block updates.
	task automatic send_beat(cmd_t c, bit typed, res_t want);
		res_t predicted;
		while ($urandom_range(0, 99) < src_idle_pct) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid        <= 1'b1;
		req_ch.kind         <= c.op;
		req_ch.level        <= c.level;
		req_ch.pulse_length <= c.length;
		req_ch.pulse_count  <= c.count;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
		predicted = predict_pulse_event(c);
		pending_results.push_back(typed ? want : predicted);
	endtask

	// Result side: takes beats at the current receiver rate and checks each
	// one against the oldest expectation.
	initial begin
		res_t exp_r;
		rsp_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (rsp_ch.valid && rsp_ch.ready) begin
				if (pending_results.size() == 0) begin
					$error("result beat with nothing expected");
					mismatches++;
				end else begin
					exp_r = pending_results.pop_front();
					if (rsp_ch.event_valid !== exp_r.event_valid) begin
						$error("event_valid: expected %0h, got %0h",
							exp_r.event_valid, rsp_ch.event_valid);
						mismatches++;
					end
					if (rsp_ch.delay !== exp_r.delay) begin
						$error("delay: expected %0h, got %0h", exp_r.delay, rsp_ch.delay);
						mismatches++;
					end
					if (rsp_ch.next_level !== exp_r.next_level) begin
						$error("next_level: expected %0h, got %0h",
							exp_r.next_level, rsp_ch.next_level);
						mismatches++;
					end
					if (rsp_ch.present_level !== exp_r.present_level) begin
						$error("present_level: expected %0h, got %0h",
							exp_r.present_level, rsp_ch.present_level);
						mismatches++;
					end
					if (rsp_ch.at_end !== exp_r.at_end) begin
						$error("at_end: expected %0h, got %0h", exp_r.at_end, rsp_ch.at_end);
						mismatches++;
					end
					if (rsp_ch.error_code !== exp_r.error_code) begin
						$error("error_code: expected %0d, got %0d",
							exp_r.error_code, rsp_ch.error_code);
						mismatches++;
					end
				end
			end
			rsp_ch.ready <= ($urandom_range(0, 99) >= sink_idle_pct) && arst_n;
		end
	end

	// Hang guard: counts cycles in which neither channel moves a beat.
	initial begin
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("tape_pulse_tone_sequencer_unit: mismatch");
		$finish;
	end

	// Main sequence: reset, directed table, random tapes in three idling
	// phases, then drain and report.
	initial begin
		int sent;
		cmd_t c;
		arst_n              = 1'b0;
		req_ch.valid        = 1'b0;
		req_ch.kind         = OP_CLEAR;
		req_ch.level        = 1'b0;
		req_ch.pulse_length = '0;
		req_ch.pulse_count  = '0;
		mismatches          = 0;
		n_loaded            = 0;
		play_pos            = 0;
		pulses_pending      = '0;
		cur_len             = '0;
		cur_direct          = 1'b0;
		level_now           = 1'b0;
		src_idle_pct        = 35;
		sink_idle_pct       = 46;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[i])
			repeat (plan[i].reps)
				send_beat(plan[i].cmd, plan[i].typed, plan[i].want);

		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			if (sent == RANDOM_ITEMS / 3) begin
				src_idle_pct  = 46;
				sink_idle_pct = 35;
			end else if (sent == 2 * RANDOM_ITEMS / 3) begin
				src_idle_pct  = 0;
				sink_idle_pct = 0;
			end
			if (cmd_backlog.size() == 0)
				plan_tape();
			c = cmd_backlog.pop_front();
			send_beat(c, 1'b0, NO_WANT);
			sent++;
		end
		req_ch.valid <= 1'b0;

		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		if (mismatches == 0)
			$display("tape_pulse_tone_sequencer_unit: match");
		else
			$display("tape_pulse_tone_sequencer_unit: mismatch");
		$finish;
	end

endmodule
